### hw/rtl/lmxy_pkg.sv
// ---------------------------------------------------------------------------
// lmxy_pkg - shared types for the LED matrix coordinate mapper
// Word formats, register indexes and the grid numbering helper.
// ---------------------------------------------------------------------------
package lmxy_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILES_ACROSS  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILES_DOWN    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATION      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAYOUT_BITS   = 3'd5;

   localparam int DIV_STEPS = 8;   // quotient bits (tile count fits 8 bits)

   typedef struct packed {
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
   } req_word_type;

   typedef struct packed {
      logic [15:0] led_index;
      logic        in_range;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] matrix_width;
      logic [7:0] matrix_height;
      logic [7:0] tiles_across;
      logic [7:0] tiles_down;
      logic [1:0] rotation;
      logic [7:0] layout_bits;
   } cfg_type;

   // physical point handed from front to back
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        in_range;
   } job_type;

   typedef struct packed {
      logic [7:0] minor;
      logic [7:0] major;
      logic [7:0] scale;
   } grid_prep_type;

   // position = major * scale + minor after this
   function automatic grid_prep_type grid_prep(input logic [7:0] col,
                                               input logic [7:0] row,
                                               input logic [7:0] cols,
                                               input logic [7:0] rows,
                                               input logic [3:0] bits);
      grid_prep_type p;
      logic [7:0]    t;
      p.minor = col;
      p.major = row;
      p.scale = cols;
      if (bits[0]) p.minor = cols - 8'd1 - p.minor;
      if (bits[1]) p.major = rows - 8'd1 - p.major;
      if (bits[2]) begin
         t       = p.minor;
         p.minor = p.major;
         p.major = t;
         p.scale = rows;
      end
      if (bits[3] && p.major[0]) p.minor = p.scale - 8'd1 - p.minor;
      return p;
   endfunction

endpackage

### hw/rtl/led_matrix_xy_to_index.sv
// ---------------------------------------------------------------------------
// led_matrix_xy_to_index - LED matrix coordinate to chain position mapper
// Maps a signed display coordinate to an LED index for single or tiled
// progressive or serpentine matrices with quarter-turn rotation.
// ---------------------------------------------------------------------------
// Use:
//   Drive req_word and raise start; the word is taken on any edge where
//   start is high and busy is low. busy only rises if the internal queue
//   fills, which does not happen as the back end drains every cycle, so a
//   word may be issued every cycle.
//   One result word per request, in order, on rsp_word with rsp_strobe high
//   for a single cycle. The receiver cannot stall: take it or lose it.
//   Throughput one word a cycle. A request passes the front capture
//   register, the queue slot, the eight-step restoring divide that splits
//   out the tile column and row, then the numbering and multiply-add stages
//   before rsp_strobe rises.
//   Registers are written through csr_we/csr_index/csr_wdata while idle;
//   indexes 6 and 7 are ignored.
//   Reset (synchronous) restores the register defaults (8x8 untiled,
//   rotation 0, progressive layout) and empties the pipeline.
// ---------------------------------------------------------------------------
module led_matrix_xy_to_index
   import lmxy_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_word_type               req_word,
   output logic                       rsp_strobe,
   output rsp_word_type               rsp_word,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   logic    accept;
   logic    job_valid_f, job_valid_q, q_full, back_ready;
   job_type job_f, job_q;

   assign accept = start && !busy;
   assign busy   = q_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix_width  <= 8'd8;
         cfg_ff.matrix_height <= 8'd8;
         cfg_ff.tiles_across  <= 8'd0;
         cfg_ff.tiles_down    <= 8'd1;
         cfg_ff.rotation      <= 2'd0;
         cfg_ff.layout_bits   <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MATRIX_WIDTH:  cfg_ff.matrix_width  <= csr_wdata;
            CSR_MATRIX_HEIGHT: cfg_ff.matrix_height <= csr_wdata;
            CSR_TILES_ACROSS:  cfg_ff.tiles_across  <= csr_wdata;
            CSR_TILES_DOWN:    cfg_ff.tiles_down    <= csr_wdata;
            CSR_ROTATION:      cfg_ff.rotation      <= csr_wdata[1:0];
            CSR_LAYOUT_BITS:   cfg_ff.layout_bits   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: capture, range check, rotate
   lmxy_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .job_valid (job_valid_f),
      .job       (job_f)
   );

   lmxy_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid_f),
      .push_job  (job_f),
      .pop_ready (back_ready),
      .pop_valid (job_valid_q),
      .pop_job   (job_q),
      .full      (q_full)
   );

   // back: tile split and numbering
   lmxy_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid_q),
      .job        (job_q),
      .cfg        (cfg_ff),
      .job_ready  (back_ready),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

### hw/rtl/lmxy_front.sv
// ---------------------------------------------------------------------------
// lmxy_front - capture, range check and rotation
// Registers the request word, checks it against the logical size and turns
// it back into physical coordinates.
// ---------------------------------------------------------------------------
module lmxy_front
   import lmxy_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   output logic         job_valid,
   output job_type      job
);

   logic         valid_ff;
   req_word_type word_ff;
   logic [15:0]  pw_ff, ph_ff;

   logic [7:0]   tx, ty;
   logic [15:0]  ux, uy, lw, lh;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) word_ff <= req_word;
      pw_ff <= 16'(cfg.matrix_width * tx);
      ph_ff <= 16'(cfg.matrix_height * ty);
   end

   always_comb begin
      tx = (cfg.tiles_across != 8'd0) ? cfg.tiles_across : 8'd1;
      ty = (cfg.tiles_across != 8'd0) ? cfg.tiles_down : 8'd1;
      ux = word_ff.coord_x;
      uy = word_ff.coord_y;
      lw = cfg.rotation[0] ? ph_ff : pw_ff;
      lh = cfg.rotation[0] ? pw_ff : ph_ff;
      job.in_range = !ux[15] && !uy[15] && (ux < lw) && (uy < lh);
      unique case (cfg.rotation)
         2'd1: begin
            job.x = pw_ff - 16'd1 - uy;
            job.y = ux;
         end
         2'd2: begin
            job.x = pw_ff - 16'd1 - ux;
            job.y = ph_ff - 16'd1 - uy;
         end
         2'd3: begin
            job.x = uy;
            job.y = ph_ff - 16'd1 - ux;
         end
         default: begin
            job.x = ux;
            job.y = uy;
         end
      endcase
   end

   assign job_valid = valid_ff;

endmodule

### hw/rtl/lmxy_queue.sv
// ---------------------------------------------------------------------------
// lmxy_queue - two-entry job queue
// Decouples the front from the back end.
// ---------------------------------------------------------------------------
module lmxy_queue
   import lmxy_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop_ready,
   output logic    pop_valid,
   output job_type pop_job,
   output logic    full
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign pop       = pop_ready && (count_ff != 2'd0);
   assign pop_valid = count_ff != 2'd0;
   assign pop_job   = mem_ff[rd_ptr_ff];
   assign full      = count_ff == 2'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

### hw/rtl/lmxy_back.sv
// ---------------------------------------------------------------------------
// lmxy_back - tile split and index pipeline
// Restoring divide by the tile size, one quotient bit a stage, then the
// tile and pixel numbering and the final multiply-add.
// ---------------------------------------------------------------------------
module lmxy_back
   import lmxy_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  job_type      job,
   input  cfg_type      cfg,
   output logic         job_ready,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   // divider lanes
   logic        dv_ff   [DIV_STEPS+1];
   logic        dok_ff  [DIV_STEPS+1];
   logic [15:0] xr_ff   [DIV_STEPS+1];
   logic [15:0] yr_ff   [DIV_STEPS+1];
   logic [7:0]  xq_ff   [DIV_STEPS+1];
   logic [7:0]  yq_ff   [DIV_STEPS+1];

   logic [15:0] area_ff;
   logic        tiled;
   logic [7:0]  tx, ty;
   logic [3:0]  tbits, mbits;
   logic [7:0]  tmajor;
   grid_prep_type tp, pp;

   // numbering stages
   logic          p1_v_ff, p1_ok_ff;
   grid_prep_type tp_ff, pp_ff;
   logic          p2_v_ff, p2_ok_ff;
   logic [15:0]   tprod_ff, pprod_ff;
   logic [7:0]    tmin_ff, pmin_ff;
   logic          p3_v_ff, p3_ok_ff;
   logic [15:0]   tnum_ff, pnum_ff;
   logic          p4_v_ff, p4_ok_ff;
   logic [15:0]   tbase_ff, pnum4_ff;
   logic          out_v_ff;
   rsp_word_type  out_ff;

   assign job_ready = 1'b1;
   assign tiled     = cfg.tiles_across != 8'd0;
   assign tx        = tiled ? cfg.tiles_across : 8'd1;
   assign ty        = tiled ? cfg.tiles_down : 8'd1;
   assign tbits     = cfg.layout_bits[7:4];

   always_ff @(posedge clock) begin
      area_ff   <= 16'(cfg.matrix_width * cfg.matrix_height);
      xr_ff[0]  <= job.x;
      yr_ff[0]  <= job.y;
      xq_ff[0]  <= 8'd0;
      yq_ff[0]  <= 8'd0;
      dok_ff[0] <= job.in_range;
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= job_valid;
      end
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      localparam int B = DIV_STEPS - 1 - s;
      logic [15:0] dx, dy;
      logic        gx, gy;
      assign dx = {8'd0, cfg.matrix_width} << B;
      assign dy = {8'd0, cfg.matrix_height} << B;
      assign gx = xr_ff[s] >= dx;
      assign gy = yr_ff[s] >= dy;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s+1] <= 1'b0;
         end else begin
            dv_ff[s+1] <= dv_ff[s];
         end
         dok_ff[s+1] <= dok_ff[s];
         xr_ff[s+1]  <= gx ? xr_ff[s] - dx : xr_ff[s];
         yr_ff[s+1]  <= gy ? yr_ff[s] - dy : yr_ff[s];
         xq_ff[s+1]  <= xq_ff[s] | (8'(gx) << B);
         yq_ff[s+1]  <= yq_ff[s] | (8'(gy) << B);
      end
   end

   always_comb begin
      tmajor = yq_ff[DIV_STEPS];
      if (tbits[1]) tmajor = ty - 8'd1 - tmajor;
      if (tbits[2]) tmajor = tbits[0] ? tx - 8'd1 - xq_ff[DIV_STEPS] : xq_ff[DIV_STEPS];
      mbits = cfg.layout_bits[3:0];
      if (tiled && tbits[3] && tmajor[0]) mbits = mbits ^ 4'd3;
      tp = grid_prep(xq_ff[DIV_STEPS], yq_ff[DIV_STEPS], tx, ty, tbits);
      pp = grid_prep(xr_ff[DIV_STEPS][7:0], yr_ff[DIV_STEPS][7:0],
                     cfg.matrix_width, cfg.matrix_height, mbits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         p3_v_ff  <= 1'b0;
         p4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         p1_v_ff  <= dv_ff[DIV_STEPS];
         p2_v_ff  <= p1_v_ff;
         p3_v_ff  <= p2_v_ff;
         p4_v_ff  <= p3_v_ff;
         out_v_ff <= p4_v_ff;
      end
      p1_ok_ff <= dok_ff[DIV_STEPS];
      tp_ff    <= tiled ? tp : '0;
      pp_ff    <= pp;
      p2_ok_ff <= p1_ok_ff;
      tprod_ff <= tp_ff.major * tp_ff.scale;
      pprod_ff <= pp_ff.major * pp_ff.scale;
      tmin_ff  <= tp_ff.minor;
      pmin_ff  <= pp_ff.minor;
      p3_ok_ff <= p2_ok_ff;
      tnum_ff  <= tprod_ff + 16'(tmin_ff);
      pnum_ff  <= pprod_ff + 16'(pmin_ff);
      p4_ok_ff <= p3_ok_ff;
      tbase_ff <= 16'(tnum_ff * area_ff);
      pnum4_ff <= pnum_ff;
      out_ff.in_range  <= p4_ok_ff;
      out_ff.led_index <= p4_ok_ff ? tbase_ff + pnum4_ff : 16'd0;
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_word   = out_ff;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the LED matrix coordinate mapper
// Sends coordinate words through the command port, predicts every chain
// position from a local copy of the layout registers and compares each
// strobed result word in order. A short table of directed points comes
// first, then random points over many matrix and tile layouts.
// ---------------------------------------------------------------------------
module tb_top;
   import lmxy_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;    // comfortably over the path from request to result
   localparam int RANDOM_WORDS   = 1500;
   localparam int MAX_REPORTS    = 10;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // local copy of the layout registers
   cfg_type      layout;
   // results still to come out, oldest first
   rsp_word_type pending_index[$];
   int           errors;
   int           quiet_cycles;

   led_matrix_xy_to_index dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // position of (col,row) in one line-ordered grid, in 32 bit arithmetic
   function automatic logic [31:0] cell_number(input logic [31:0] col,
                                               input logic [31:0] row,
                                               input logic [31:0] cols,
                                               input logic [31:0] rows,
                                               input logic [3:0]  bits);
      logic [31:0] minor;
      logic [31:0] major;
      logic [31:0] scale;
      logic [31:0] t;
      minor = col;
      major = row;
      scale = cols;
      if (bits[0]) minor = cols - 1 - minor;
      if (bits[1]) major = rows - 1 - major;
      if (bits[2]) begin
         t     = minor;
         minor = major;
         major = t;
         scale = rows;
      end
      if (bits[3] && major[0]) return (major + 1) * scale - 1 - minor;
      return major * scale + minor;
   endfunction

   // logical width and height for the given layout
   function automatic logic [31:0] logical_size(input cfg_type c, input bit want_height);
      logic [31:0] pw;
      logic [31:0] ph;
      pw = c.matrix_width  * ((c.tiles_across != 0) ? c.tiles_across : 32'd1);
      ph = c.matrix_height * ((c.tiles_across != 0) ? c.tiles_down   : 32'd1);
      if (c.rotation[0] ^ want_height) return ph;
      return pw;
   endfunction

   function automatic rsp_word_type map_point(input cfg_type c, input req_word_type r);
      rsp_word_type res;
      logic [31:0]  rx, ry, tx, ty, pw, ph, lw, lh, x, y;
      logic [31:0]  tcol, trow, tmajor, index;
      logic [3:0]   mbits, tbits;
      bit           tiled;
      rx    = {16'd0, r.coord_x};
      ry    = {16'd0, r.coord_y};
      tiled = c.tiles_across != 0;
      tx    = tiled ? c.tiles_across : 32'd1;
      ty    = tiled ? c.tiles_down   : 32'd1;
      pw    = c.matrix_width  * tx;
      ph    = c.matrix_height * ty;
      lw    = c.rotation[0] ? ph : pw;
      lh    = c.rotation[0] ? pw : ph;
      res   = '0;
      // negative or beyond the logical size: off the display
      if (rx[15] || ry[15] || rx >= lw || ry >= lh) return res;
      case (c.rotation)
         2'd1: begin x = pw - 1 - ry; y = rx;          end
         2'd2: begin x = pw - 1 - rx; y = ph - 1 - ry; end
         2'd3: begin x = ry;          y = ph - 1 - rx; end
         default: begin x = rx; y = ry; end
      endcase
      mbits = c.layout_bits[3:0];
      index = 0;
      if (tiled) begin
         tcol  = x / c.matrix_width;
         trow  = y / c.matrix_height;
         tbits = c.layout_bits[7:4];
         x     = x - tcol * c.matrix_width;
         y     = y - trow * c.matrix_height;
         tmajor = trow;
         if (tbits[1]) tmajor = ty - 1 - tmajor;
         if (tbits[2]) tmajor = tbits[0] ? tx - 1 - tcol : tcol;
         // odd zigzag tile line: pixel corner flips both ways
         if (tbits[3] && tmajor[0]) mbits = mbits ^ 4'b0011;
         index = cell_number(tcol, trow, tx, ty, tbits) * c.matrix_width * c.matrix_height;
      end
      index = index + cell_number(x, y, c.matrix_width, c.matrix_height, mbits);
      res.led_index = index[15:0];
      res.in_range  = 1'b1;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // write enable stays up across back-to-back writes; load_layout drops it
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MATRIX_WIDTH:  layout.matrix_width  = val;
         CSR_MATRIX_HEIGHT: layout.matrix_height = val;
         CSR_TILES_ACROSS:  layout.tiles_across  = val;
         CSR_TILES_DOWN:    layout.tiles_down    = val;
         CSR_ROTATION:      layout.rotation      = val[1:0];
         CSR_LAYOUT_BITS:   layout.layout_bits   = val;
         default: ;
      endcase
   endtask

   // registers change only with the pipe empty
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_index.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_layout(input logic [7:0] mw, input logic [7:0] mh,
                              input logic [7:0] ta, input logic [7:0] td,
                              input logic [1:0] rot, input logic [7:0] lb);
      wait_idle();
      write_reg(CSR_MATRIX_WIDTH, mw);
      write_reg(CSR_MATRIX_HEIGHT, mh);
      write_reg(CSR_TILES_ACROSS, ta);
      write_reg(CSR_TILES_DOWN, td);
      write_reg(CSR_ROTATION, {6'd0, rot});
      write_reg(CSR_LAYOUT_BITS, lb);
      csr_we <= 1'b0;
   endtask

   // hold start high until the word is taken; start may stay high into the next word
   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type typed_res,
                            input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pending_index.push_back(typed ? typed_res : map_point(layout, w));
   endtask

   function automatic logic [15:0] pick_coord(input logic [31:0] span);
      logic [31:0] top;
      int          sel;
      sel = $urandom_range(9);
      top = (span > 32767) ? 32'd32767 : span;
      if (sel < 7) return 16'($urandom_range(0, top));   // mostly on or just past the edge
      if (sel < 8) return 16'(top - $urandom_range(0, 2));
      return 16'($urandom);                               // full range noise
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_index.size() == 0) begin
            errors <= errors + 1;
            if (errors < MAX_REPORTS)
               $display("unexpected result word: index %0d range %0b",
                        rsp_word.led_index, rsp_word.in_range);
         end else begin
            want = pending_index.pop_front();
            if (want.led_index !== rsp_word.led_index || want.in_range !== rsp_word.in_range) begin
               errors <= errors + 1;
               if (errors < MAX_REPORTS)
                  $display("mismatch: want index %0d range %0b, got index %0d range %0b",
                           want.led_index, want.in_range,
                           rsp_word.led_index, rsp_word.in_range);
            end
         end
      end
   end

   // watchdog: cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed table: x, y, and a typed expectation where obvious
   // ------------------------------------------------------------------
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      bit                 typed;
      logic [15:0]        led_index;
      logic               in_range;
   } point_row_type;

   point_row_type points[] = '{
      '{16'sd0,      16'sd0,      1, 16'd0,  1'b1},   // origin after reset
      '{16'sd7,      16'sd7,      1, 16'd63, 1'b1},   // far corner of 8x8
      '{16'sd7,      16'sd0,      1, 16'd7,  1'b1},
      '{16'sd0,      16'sd7,      1, 16'd56, 1'b1},
      '{16'sd8,      16'sd0,      1, 16'd0,  1'b0},   // just past right edge
      '{16'sd0,      16'sd8,      1, 16'd0,  1'b0},
      '{-16'sd1,     16'sd0,      1, 16'd0,  1'b0},   // negative
      '{16'sd0,      -16'sd1,     1, 16'd0,  1'b0},
      '{-16'sd32768, -16'sd32768, 1, 16'd0,  1'b0},
      '{16'sd32767,  16'sd32767,  1, 16'd0,  1'b0},
      '{16'sd3,      16'sd5,      0, 16'd0,  1'b0},
      '{16'sd6,      16'sd1,      0, 16'd0,  1'b0}
   };

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_word_type w;
      rsp_word_type r;
      logic [31:0]  lw, lh;
      int           idle_pct;
      int           sent;
      reset     = 1'b1;
      start     = 1'b0;
      req_word  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors    = 0;
      layout    = '{matrix_width: 8'd8, matrix_height: 8'd8, tiles_across: 8'd0,
                    tiles_down: 8'd1, rotation: 2'd0, layout_bits: 8'd0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (points[i]) begin
         w.coord_x   = points[i].x;
         w.coord_y   = points[i].y;
         r.led_index = points[i].led_index;
         r.in_range  = points[i].in_range;
         send_word(w, points[i].typed, r, 0);
      end

      // random in-range points under zigzag tiles and rotations, then a wrapping chain
      load_layout(8'd4, 8'd3, 8'd3, 8'd2, 2'd1, 8'hFF);
      for (int i = 0; i < 6; i++) begin
         w.coord_x = 16'($urandom_range(0, 5));
         w.coord_y = 16'($urandom_range(0, 11));
         send_word(w, 0, r, 0);
      end
      load_layout(8'd255, 8'd255, 8'd255, 8'd255, 2'd3, 8'h5A);
      w.coord_x = 16'sd32767; w.coord_y = 16'sd32767; send_word(w, 0, r, 0);
      w.coord_x = 16'sd0;     w.coord_y = 16'sd0;     send_word(w, 0, r, 0);
      load_layout(8'd0, 8'd0, 8'd0, 8'd0, 2'd2, 8'h00);   // empty display
      w.coord_x = 16'sd0; w.coord_y = 16'sd0; send_word(w, 0, r, 0);

      // random points, layout changed every 100 words
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(7))
            0: load_layout(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           2'($urandom), 8'($urandom));
            1: load_layout(8'd255, 8'd1, 8'd0, 8'($urandom), 2'($urandom), 8'($urandom));
            2: load_layout(8'd1, 8'd255, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                           2'($urandom), 8'($urandom));
            default: load_layout(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                                 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                                 2'($urandom), 8'($urandom));
         endcase
         lw = logical_size(layout, 0);
         lh = logical_size(layout, 1);
         for (int i = 0; i < 100; i++) begin
            idle_pct = (sent < 500) ? 25 : (sent < 1000) ? 86 : 0;
            w.coord_x = pick_coord(lw);
            w.coord_y = pick_coord(lh);
            send_word(w, 0, r, idle_pct);
            sent++;
         end
      end

      start <= 1'b0;
      while (pending_index.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_index.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
